### rtl/nearest_palette_color_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette colour block
// Shared property shapes, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// Antecedent in one cycle implies consequent in the next.
`define NPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error("npc: next-cycle property violated");

// Antecedent in one cycle implies the signal holds its value into the next.
`define NPC_ASSERT_HOLD(label, ante, sig) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> $stable(sig)) else $error("npc: held value changed");

`endif

### rtl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Types and constants shared by the nearest palette colour block.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int unsigned COLOUR_W = 8;
  localparam int unsigned QUERY_W  = 6;   // query byte after the shift by two
  localparam int unsigned PIXEL_W  = 3 * COLOUR_W;
  localparam int unsigned SQ_W     = 2 * COLOUR_W;
  // 3 * 255^2 = 195075 fits in 18 bits
  localparam int unsigned DIST_W   = 18;
  localparam logic [DIST_W-1:0] BEST_START = '1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [QUERY_W-1:0] red;
    logic [QUERY_W-1:0] green;
    logic [QUERY_W-1:0] blue;
  } npc_qcol_t;

  typedef struct packed {
    logic vld;
    logic last;
  } npc_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } npc_state_e;

endpackage

### rtl/npc_req_if.sv
// ----------------------------------------------------------------------------
// npc_req_if
// Request channel: palette load or nearest colour query.
// ----------------------------------------------------------------------------
interface npc_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, func, entry_index, red, green, blue, input ready);
  modport sink   (input valid, func, entry_index, red, green, blue, output ready);
endinterface

### rtl/npc_rsp_if.sv
// ----------------------------------------------------------------------------
// npc_rsp_if
// Response channel: index of the nearest palette entry.
// ----------------------------------------------------------------------------
interface npc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] nearest_index;

  modport source (output valid, nearest_index, input ready);
  modport sink   (input valid, nearest_index, output ready);
endinterface

### rtl/nearest_palette_color.sv
// ----------------------------------------------------------------------------
// nearest_palette_color
// Palette store with a nearest colour search by squared Euclidean distance.
// ----------------------------------------------------------------------------
//
//  channel  | dir | modport | carries
//  ---------+-----+---------+---------------------------------------------
//  req_i    | in  | sink    | func, entry_index, red, green, blue
//  rsp_o    | out | source  | nearest_index (one per query, none per load)
//
// A load request writes its entry into the palette on acceptance.
// A query reads the palette RAM through its single read port, one entry a cycle;
// each entry passes the read register and npc_dist into the running minimum.
// No request is taken during a scan; the result register lets the next
// request in while a response still waits on rsp_o.ready.
// Reset clears control state only; palette contents are unknown until loaded.
//
module nearest_palette_color #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  npc_req_if.sink   req_i,
  npc_rsp_if.source rsp_o
);

  localparam int unsigned IdxW   = $clog2(PALETTE_ENTRIES);
  localparam int unsigned PW     = npc_pkg::PIXEL_W;
  localparam int unsigned DW     = npc_pkg::DIST_W;
  localparam int unsigned QW     = npc_pkg::QUERY_W;
  localparam logic [8:0]  NumEnt = 9'(PALETTE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PALETTE_ENTRIES - 1);

  // --- control -------------------------------------------------------------
  npc_pkg::npc_state_e state_q, state_d;

  logic req_acc, is_query, is_load, load_hit;
  logic req_ready;
  logic scan_en;      // issue a palette read this cycle
  logic result_load;  // move the final best index into the result register
  logic addr_last;

  // --- datapath ------------------------------------------------------------
  logic [PW-1:0]      palette_mem [PALETTE_ENTRIES];
  logic [PW-1:0]      rdata_q;
  logic [IdxW-1:0]    addr_q, addr_d;
  logic [IdxW-1:0]    rd_idx_q;
  npc_pkg::npc_tag_t  rd_tag_q, rd_tag_d;
  npc_pkg::npc_qcol_t query_q;

  logic [DW-1:0]      cand_dist;
  npc_pkg::npc_tag_t  dist_tag;
  logic [IdxW-1:0]    dist_idx;
  logic [DW-1:0]      best_q, best_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;

  logic               out_vld_q, out_vld_d;
  logic [7:0]         out_idx_q;

  assign req_acc  = req_i.valid & req_ready;
  assign is_query = req_i.func == npc_pkg::FUNC_QUERY;
  assign is_load  = req_i.func == npc_pkg::FUNC_LOAD;
  // loads beyond the palette are dropped
  assign load_hit = req_acc & is_load & ({1'b0, req_i.entry_index} < NumEnt);
  assign addr_last = addr_q == LastIdx;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npc_pkg::ST_IDLE:  if (req_acc && is_query) state_d = npc_pkg::ST_SCAN;
      npc_pkg::ST_SCAN:  if (addr_last) state_d = npc_pkg::ST_DRAIN;
      npc_pkg::ST_DRAIN: if (dist_tag.vld && dist_tag.last) state_d = npc_pkg::ST_DONE;
      npc_pkg::ST_DONE:  if (!out_vld_q || rsp_o.ready) state_d = npc_pkg::ST_IDLE;
      default:           state_d = npc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_ready   = 1'b0;
    scan_en     = 1'b0;
    result_load = 1'b0;
    unique case (state_q)
      npc_pkg::ST_IDLE:  req_ready   = 1'b1;
      npc_pkg::ST_SCAN:  scan_en     = 1'b1;
      npc_pkg::ST_DRAIN: ;
      npc_pkg::ST_DONE:  result_load = !out_vld_q || rsp_o.ready;
      default:           ;
    endcase
  end

  assign req_i.ready = req_ready;

  // scan address: restarts from entry 0 on every query
  always_comb begin
    addr_d = addr_q;
    if (req_acc && is_query) begin
      addr_d = '0;
    end else if (scan_en) begin
      addr_d = addr_q + IdxW'(1);
    end
  end

  assign rd_tag_d = '{vld: scan_en, last: scan_en & addr_last};

  // palette RAM: one write port (loads), one registered read port (scan).
  // Loads are only taken while idle, so scan reads and writes never collide.
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      palette_mem[req_i.entry_index[IdxW-1:0]] <= {req_i.red, req_i.green, req_i.blue};
    end
    rdata_q  <= palette_mem[addr_q];
    rd_idx_q <= addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && is_query) begin
      query_q <= '{red:   req_i.red[7:8-QW],
                   green: req_i.green[7:8-QW],
                   blue:  req_i.blue[7:8-QW]};
    end
  end

  npc_dist #(
    .IdxW (IdxW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .query_i (query_q),
    .pixel_i (rdata_q),
    .tag_i   (rd_tag_q),
    .idx_i   (rd_idx_q),
    .dist_o  (cand_dist),
    .tag_o   (dist_tag),
    .idx_o   (dist_idx)
  );

  // running minimum; strict compare keeps the lowest index on ties
  always_comb begin
    best_d     = best_q;
    best_idx_d = best_idx_q;
    priority if (req_acc && is_query) begin
      best_d     = npc_pkg::BEST_START;
      best_idx_d = '0;
    end else if (dist_tag.vld && (cand_dist < best_q)) begin
      best_d     = cand_dist;
      best_idx_d = dist_idx;
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    priority if (result_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= npc_pkg::ST_IDLE;
      addr_q    <= '0;
      rd_tag_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      rd_tag_q  <= rd_tag_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    if (result_load) begin
      out_idx_q <= 8'(best_idx_q);
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.nearest_index = out_idx_q;

endmodule

### rtl/npc_dist.sv
// ----------------------------------------------------------------------------
// npc_dist
// Two-stage squared Euclidean distance between a query and one palette entry.
// ----------------------------------------------------------------------------
module npc_dist #(
  parameter int unsigned IdxW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  npc_pkg::npc_qcol_t            query_i,
  input  logic [npc_pkg::PIXEL_W-1:0]   pixel_i,
  input  npc_pkg::npc_tag_t             tag_i,
  input  logic [IdxW-1:0]               idx_i,
  output logic [npc_pkg::DIST_W-1:0]    dist_o,
  output npc_pkg::npc_tag_t             tag_o,
  output logic [IdxW-1:0]               idx_o
);

  localparam int unsigned CW = npc_pkg::COLOUR_W;
  localparam int unsigned SW = npc_pkg::SQ_W;
  localparam int unsigned DW = npc_pkg::DIST_W;

  logic [CW-1:0] q_r, q_g, q_b;
  logic [CW-1:0] d_r, d_g, d_b;
  logic [SW-1:0] sq_r_q, sq_g_q, sq_b_q;
  logic [SW-1:0] sq_r_d, sq_g_d, sq_b_d;
  npc_pkg::npc_tag_t tag1_q, tag2_q;
  logic [IdxW-1:0]   idx1_q, idx2_q;
  logic [DW-1:0]     dist_q, dist_d;

  assign q_r = CW'(query_i.red);
  assign q_g = CW'(query_i.green);
  assign q_b = CW'(query_i.blue);

  // absolute differences, entry bytes unshifted
  always_comb begin
    d_r = (q_r > pixel_i[3*CW-1:2*CW]) ? q_r - pixel_i[3*CW-1:2*CW]
                                       : pixel_i[3*CW-1:2*CW] - q_r;
    d_g = (q_g > pixel_i[2*CW-1:CW]) ? q_g - pixel_i[2*CW-1:CW]
                                     : pixel_i[2*CW-1:CW] - q_g;
    d_b = (q_b > pixel_i[CW-1:0]) ? q_b - pixel_i[CW-1:0]
                                  : pixel_i[CW-1:0] - q_b;
    sq_r_d = SW'(d_r) * SW'(d_r);
    sq_g_d = SW'(d_g) * SW'(d_g);
    sq_b_d = SW'(d_b) * SW'(d_b);
  end

  assign dist_d = DW'(sq_r_q) + DW'(sq_g_q) + DW'(sq_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= sq_r_d;
    sq_g_q <= sq_g_d;
    sq_b_q <= sq_b_d;
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;
  assign tag_o  = tag2_q;
  assign idx_o  = idx2_q;

endmodule

### rtl/npc_checker.sv
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks on the nearest palette colour block, bound to the top.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_assert.svh"

module npc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       req_func_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_index_i
);

  logic req_acc, rsp_stall;

  assign req_acc   = req_valid_i & req_ready_i;
  assign rsp_stall = rsp_valid_i & !rsp_ready_i;

  // a query closes the request side for its scan
  `NPC_ASSERT_NEXT(a_query_blocks, req_acc && (req_func_i == npc_pkg::FUNC_QUERY), !req_ready_i)
  // a load never closes the request side
  `NPC_ASSERT_NEXT(a_load_keeps_ready, req_acc && (req_func_i == npc_pkg::FUNC_LOAD), req_ready_i)
  // a stalled response stays up with the same index
  `NPC_ASSERT_NEXT(a_rsp_held, rsp_stall, rsp_valid_i)
  `NPC_ASSERT_HOLD(a_rsp_stable, rsp_stall, rsp_index_i)

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_func_i  (req_i.func),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_index_i (rsp_o.nearest_index)
);

### bench/nearest_palette_color_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_palette_color_tb
// Fills the whole palette, then drives a directed and a random mix of palette
// loads and colour queries with varying back-pressure on both channels. Every
// returned index is checked against a software search of a mirrored palette.
// ----------------------------------------------------------------------------
module nearest_palette_color_tb;

  localparam int unsigned PALETTE_SIZE   = 256;
  localparam int unsigned RANDOM_ITEMS   = 175;
  // a query scans all PALETTE_SIZE entries, then drains through the pipeline
  localparam int unsigned DRAIN_CYCLES   = PALETTE_SIZE + 40;
  // longest quiet stretch of a correct run is one scan plus a receiver stall
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic clk_i;
  logic rst_ni = 1'b0;

  npc_req_if req_if ();
  npc_rsp_if rsp_if ();

  nearest_palette_color i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Mirrors the palette and keeps the indices still owed by the block, oldest
  // first. Loads only update the mirror; a query pushes the index it should
  // return.
  class palette_tracker;
    logic [7:0]  pal_red   [PALETTE_SIZE];
    logic [7:0]  pal_green [PALETTE_SIZE];
    logic [7:0]  pal_blue  [PALETTE_SIZE];
    logic [7:0]  pending_nearest [$];
    int unsigned loads;
    int unsigned queries;
    int unsigned tied_queries;
    int unsigned mismatches;

    // Exhaustive search in index order. Query bytes lose their two low bits,
    // stored bytes are used as they are; only a strictly smaller distance
    // moves the best, so the first of equal entries is kept.
    function logic [7:0] nearest_entry(logic [7:0] red, logic [7:0] green,
                                       logic [7:0] blue);
      int          dr, dg, db;
      int unsigned sq_dist;
      int unsigned best;
      logic [7:0]  best_idx;
      bit          tied;
      best     = 32'h7fff_ffff;
      best_idx = '0;
      tied     = 1'b0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        dr      = int'(red   >> 2) - int'(pal_red[i]);
        dg      = int'(green >> 2) - int'(pal_green[i]);
        db      = int'(blue  >> 2) - int'(pal_blue[i]);
        sq_dist = dr * dr + dg * dg + db * db;
        if (sq_dist < best) begin
          best     = sq_dist;
          best_idx = i[7:0];
          tied     = 1'b0;
        end else if (sq_dist == best) begin
          tied = 1'b1;
        end
      end
      if (tied) tied_queries++;
      return best_idx;
    endfunction

    function void note_request(logic func, logic [7:0] idx, logic [7:0] red,
                               logic [7:0] green, logic [7:0] blue);
      if (func == npc_pkg::FUNC_LOAD) begin
        loads++;
        if (idx < PALETTE_SIZE) begin
          pal_red[idx]   = red;
          pal_green[idx] = green;
          pal_blue[idx]  = blue;
        end
      end else begin
        queries++;
        pending_nearest.push_back(nearest_entry(red, green, blue));
      end
    endfunction

    function void check_index(logic [7:0] got);
      logic [7:0] want;
      if (pending_nearest.size() == 0) begin
        $error("nearest_index: expected none, actual %0d", got);
        mismatches++;
      end else begin
        want = pending_nearest.pop_front();
        if (got !== want) begin
          $error("nearest_index: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  palette_tracker board = new();

  // idling odds, in percent, for the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Request side. Every change happens at the falling edge and acceptance is
  // seen at the rising edge. valid gets a single assignment per time step: an
  // idle cycle lowers it and the next request raises it again.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic func, input logic [7:0] idx,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= func;
    req_if.entry_index <= idx;
    req_if.red         <= red;
    req_if.green       <= green;
    req_if.blue        <= blue;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(func, idx, red, green, blue);
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
    send_request(npc_pkg::FUNC_LOAD, idx, red, green, blue);
  endtask

  // entry_index is don't-care on a query, so it carries noise
  task automatic query_colour(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
    send_request(npc_pkg::FUNC_QUERY, 8'($urandom), red, green, blue);
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready is redrawn every falling edge, results are taken at
  // the rising edge.
  // --------------------------------------------------------------------------
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) board.check_index(rsp_if.nearest_index);
    end
  end

  // Hang detector: any accepted request or response restarts the count.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL nearest_palette_color");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0]  src;
    logic [7:0]  dst;
    int unsigned pick;
    logic [7:0]  col [3];

    req_if.valid       = 1'b0;
    req_if.func        = npc_pkg::FUNC_LOAD;
    req_if.entry_index = '0;
    req_if.red         = '0;
    req_if.green       = '0;
    req_if.blue        = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Palette contents are unknown after reset, so every entry is written
    // before the first query. Values all sit in the reachable 0..63 band.
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      load_entry(i[7:0], 8'($urandom_range(63)), 8'($urandom_range(63)),
                 8'($urandom_range(63)));
    end

    // ---- directed part ----
    load_entry(8'd0,   8'd0,   8'd0,   8'd0);     // lowest index, black
    load_entry(8'd255, 8'd255, 8'd255, 8'd255);   // highest index, white
    load_entry(8'd17,  8'd63,  8'd63,  8'd63);    // same colour twice: tie
    load_entry(8'd200, 8'd63,  8'd63,  8'd63);
    load_entry(8'd5,   8'd10,  8'd20,  8'd30);    // adjacent duplicate pair
    load_entry(8'd6,   8'd10,  8'd20,  8'd30);
    load_entry(8'd128, 8'd255, 8'd0,   8'd0);
    query_colour(8'd0,   8'd0,   8'd0);
    query_colour(8'd255, 8'd255, 8'd255);         // tie at the top of the range
    query_colour(8'd3,   8'd3,   8'd3);           // low bits shifted away
    query_colour(8'd43,  8'd82,  8'd121);         // exact after the shift, tie
    query_colour(8'd255, 8'd0,   8'd0);           // stored byte beyond 63
    query_colour(8'hAA,  8'h55,  8'hAA);
    query_colour(8'h80,  8'h40,  8'h20);          // one bit a byte
    query_colour(8'h10,  8'h08,  8'h04);
    query_colour(8'h02,  8'h01,  8'hFF);
    load_entry(8'd0,   8'd255, 8'd255, 8'd255);   // entry 0 moved away
    query_colour(8'd0,   8'd0,   8'd0);
    load_entry(8'd0,   8'd0,   8'd0,   8'd0);

    // ---- random part, four back-pressure phases ----
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      pick = $urandom_range(99);
      if (pick < 40) begin
        // fresh entry, usually inside the band a query can reach
        for (int c = 0; c < 3; c++)
          col[c] = ($urandom_range(9) < 7) ? 8'($urandom_range(63)) : 8'($urandom);
        load_entry(8'($urandom), col[0], col[1], col[2]);
      end else if (pick < 52) begin
        // copy an existing entry elsewhere so that ties keep turning up
        src = 8'($urandom);
        dst = 8'($urandom);
        load_entry(dst, board.pal_red[src], board.pal_green[src],
                   board.pal_blue[src]);
      end else if (pick < 72) begin
        // aim at a stored colour, with random low bits under the shift
        src = 8'($urandom);
        query_colour({board.pal_red[src][5:0],   2'($urandom)},
                     {board.pal_green[src][5:0], 2'($urandom)},
                     {board.pal_blue[src][5:0],  2'($urandom)});
      end else begin
        query_colour(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // let the owed results come back, then watch for strays
    while (board.pending_nearest.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d palette loads and %0d nearest colour queries,",
             board.loads, board.queries);
    $display("%0d of the queries had more than one entry at the best distance.",
             board.tied_queries);
    if (board.mismatches == 0) begin
      $display("PASS nearest_palette_color");
    end else begin
      $display("FAIL nearest_palette_color");
    end
    $finish;
  end

endmodule
